>>> hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int VAL_W    = 16;
    localparam int PRI_W    = 8;
    localparam int FILL_W   = 5;
    localparam int STATUS_W = 2;

    // operation codes carried on the slave tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // result status codes carried on the master tuser
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // control broadcast from the top level to every slot
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [VAL_W-1:0] val;
        logic [PRI_W-1:0] pri;
    } t_cell_ctl;

endpackage

>>> hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a value and its priority, compares the
// incoming priority and shifts toward the back on insert, forward on remove.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic             i_in_range,
    input  logic             i_le_prev,
    input  logic [VAL_W-1:0] i_prev_val,
    input  logic [PRI_W-1:0] i_prev_pri,
    input  logic [VAL_W-1:0] i_next_val,
    input  logic [PRI_W-1:0] i_next_pri,
    output logic             o_le,
    output logic [VAL_W-1:0] o_val,
    output logic [PRI_W-1:0] o_pri
);

    logic [VAL_W-1:0] r_val;
    logic [PRI_W-1:0] r_pri;
    logic [VAL_W-1:0] n_val;
    logic [PRI_W-1:0] n_pri;

    // held entry stays ahead of the new one when its priority is not larger
    assign o_le  = i_in_range && (r_pri <= i_ctl.pri);
    assign o_val = r_val;
    assign o_pri = r_pri;

    always_comb begin
        n_val = r_val;
        n_pri = r_pri;
        if (i_ctl.ins) begin
            if (!o_le) begin
                if (i_le_prev) begin
                    n_val = i_ctl.val;
                    n_pri = i_ctl.pri;
                end else begin
                    n_val = i_prev_val;
                    n_pri = i_prev_pri;
                end
            end
        end else if (i_ctl.rem) begin
            n_val = i_next_val;
            n_pri = i_next_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_pri <= n_pri;
    end

endmodule

>>> hw/rtl/spq_array.sv
// ----------------------------------------------------------------------------
// spq_array
// Row of slots kept in priority order; slot zero is the front of the queue.
// ----------------------------------------------------------------------------
module spq_array
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
)
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_count,
    output logic [VAL_W-1:0] o_front_val,
    output logic [PRI_W-1:0] o_front_pri
);

    logic [DEPTH-1:0] le;
    logic [VAL_W-1:0] val [DEPTH];
    logic [PRI_W-1:0] pri [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_slot
            logic             in_range;
            logic             le_prev;
            logic [VAL_W-1:0] prev_val;
            logic [PRI_W-1:0] prev_pri;
            logic [VAL_W-1:0] next_val;
            logic [PRI_W-1:0] next_pri;

            assign in_range = ({1'b0, i_count} > (CNT_W+1)'(gi));

            if (gi == 0) begin : g_first
                assign le_prev  = 1'b1;
                assign prev_val = '0;
                assign prev_pri = '0;
            end else begin : g_mid
                assign le_prev  = le[gi-1];
                assign prev_val = val[gi-1];
                assign prev_pri = pri[gi-1];
            end

            // last slot holds on remove; it lies beyond the fill anyway
            if (gi == DEPTH-1) begin : g_last
                assign next_val = val[gi];
                assign next_pri = pri[gi];
            end else begin : g_inner
                assign next_val = val[gi+1];
                assign next_pri = pri[gi+1];
            end

            spq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (i_ctl),
                .i_in_range (in_range),
                .i_le_prev  (le_prev),
                .i_prev_val (prev_val),
                .i_prev_pri (prev_pri),
                .i_next_val (next_val),
                .i_next_pri (next_pri),
                .o_le       (le[gi]),
                .o_val      (val[gi]),
                .o_pri      (pri[gi])
            );
        end
    endgenerate

    assign o_front_val = val[0];
    assign o_front_pri = pri[0];

endmodule

>>> hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a sorted row of slots; insert and remove
// complete in one pass of parallel compare and shift.
// ----------------------------------------------------------------------------
// Path: an item passes the input register, then the result register; the slot
//   row updates on the same edge as the result register.
// Throughput: one item per cycle while the output side does not stall; the
//   compare and shift runs in parallel across all DEPTH slots.
// Reset: synchronous active low; clears the fill count and both valid flags.
//   Slot contents are not reset and are read only below the fill count.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [15:0] item_value, [23:16] priority_req
    input  logic [0:0]  i_s_tuser,   // [0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] out_value, [23:16] out_priority,
                                     // [28:24] fill_count, [31:29] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // input register
    logic             r_in_valid;
    logic             r_in_mode;
    logic [VAL_W-1:0] r_in_val;
    logic [PRI_W-1:0] r_in_pri;

    // queue fill
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [VAL_W-1:0]    r_out_val;
    logic [PRI_W-1:0]    r_out_pri;
    logic [FILL_W-1:0]   r_out_fill;

    logic                advance;
    logic                commit;
    logic                is_full;
    logic                is_empty;
    logic                ins_ok;
    logic                rem_ok;
    logic [STATUS_W-1:0] n_status;
    logic [VAL_W-1:0]    n_val;
    logic [PRI_W-1:0]    n_pri;
    logic [FILL_W-1:0]   n_fill;
    logic [CNT_W+FILL_W-1:0] fill_ext;
    logic [VAL_W-1:0]    front_val;
    logic [PRI_W-1:0]    front_pri;
    t_cell_ctl           cell_ctl;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign commit     = r_in_valid && advance;

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);
    assign ins_ok   = commit && (r_in_mode == MODE_INSERT) && !is_full;
    assign rem_ok   = commit && (r_in_mode == MODE_REMOVE) && !is_empty;

    assign cell_ctl.ins = ins_ok;
    assign cell_ctl.rem = rem_ok;
    assign cell_ctl.val = r_in_val;
    assign cell_ctl.pri = r_in_pri;

    spq_array #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_array (
        .i_clk       (i_clk),
        .i_ctl       (cell_ctl),
        .i_count     (r_count),
        .o_front_val (front_val),
        .o_front_pri (front_pri)
    );

    always_comb begin
        n_count = r_count;
        n_val   = '0;
        n_pri   = '0;
        if (r_in_mode == MODE_INSERT) begin
            n_status = is_full ? ST_FULL : ST_INSERTED;
            if (ins_ok) begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            n_status = is_empty ? ST_EMPTY : ST_REMOVED;
            if (!is_empty) begin
                n_val = front_val;
                n_pri = front_pri;
            end
            if (rem_ok) begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    // fill count on the port keeps only its low bits
    assign fill_ext = {{FILL_W{1'b0}}, n_count};
    assign n_fill   = fill_ext[FILL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (commit) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_mode <= i_s_tuser[0];
            r_in_val  <= i_s_tdata[15:0];
            r_in_pri  <= i_s_tdata[23:16];
        end
        if (commit) begin
            r_out_status <= n_status;
            r_out_val    <= n_val;
            r_out_pri    <= n_pri;
            r_out_fill   <= n_fill;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {3'b000, r_out_fill, r_out_pri, r_out_val};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_ok |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not decrement fill count");

    a_insert_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_ok |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not increment fill count");

    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && !ins_ok && !rem_ok) |=> $stable(r_count))
        else $error("rejected item changed fill count");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_REMOVED) |->
            (r_out_val == '0 && r_out_pri == '0))
        else $error("nonzero payload on a result without a removed entry");

endmodule

>>> dv/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue. A cycle-free model of
// the sorted list predicts status, removed entry and fill count for every
// transfer. Stimulus is a short directed pass (empty, full, ties, extreme
// fields), then random bursts that swing the queue between empty and full,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue
    import spq_pkg::*;
();

    localparam int DEPTH       = 16;
    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_TAIL   = 60;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    value;
        logic [PRI_W-1:0]    pri;
        logic [FILL_W-1:0]   fill;
    } t_queue_result;

    // Sorted-list model of the queue plus the store of pending results.
    class queue_scoreboard;
        logic [VAL_W-1:0] held_value [DEPTH];
        logic [PRI_W-1:0] held_pri [DEPTH];
        int               held_count;
        t_queue_result    pending_q [$];
        int               fail_count;
        int               n_inserted;
        int               n_removed;
        int               n_empty;
        int               n_full;
        int               peak_fill;

        function void note_item(logic mode, logic [VAL_W-1:0] val, logic [PRI_W-1:0] pri);
            t_queue_result r;
            int            slot;
            r = '0;
            if (mode == MODE_INSERT) begin
                if (held_count >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    // insert after every entry of equal or better priority
                    slot = 0;
                    while (slot < held_count && held_pri[slot] <= pri)
                        slot++;
                    for (int k = held_count; k > slot; k--) begin
                        held_value[k] = held_value[k-1];
                        held_pri[k]   = held_pri[k-1];
                    end
                    held_value[slot] = val;
                    held_pri[slot]   = pri;
                    held_count++;
                    r.status = ST_INSERTED;
                    n_inserted++;
                end
            end else begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    r.value  = held_value[0];
                    r.pri    = held_pri[0];
                    for (int k = 1; k < held_count; k++) begin
                        held_value[k-1] = held_value[k];
                        held_pri[k-1]   = held_pri[k];
                    end
                    held_count--;
                    r.status = ST_REMOVED;
                    n_removed++;
                end
            end
            r.fill = held_count[FILL_W-1:0];
            if (held_count > peak_fill)
                peak_fill = held_count;
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [31:0] tdata, logic [1:0] tuser);
            t_queue_result want;
            if (pending_q.size() == 0) begin
                $error("unexpected result: status %0d data %h", tuser, tdata);
                fail_count++;
                return;
            end
            want = pending_q.pop_front();
            if (tuser != want.status) begin
                $error("status: expected %0d, actual %0d", want.status, tuser);
                fail_count++;
            end
            if (tdata[15:0] != want.value) begin
                $error("out_value: expected %h, actual %h", want.value, tdata[15:0]);
                fail_count++;
            end
            if (tdata[23:16] != want.pri) begin
                $error("out_priority: expected %0d, actual %0d", want.pri, tdata[23:16]);
                fail_count++;
            end
            if (tdata[28:24] != want.fill) begin
                $error("fill_count: expected %0d, actual %0d", want.fill, tdata[28:24]);
                fail_count++;
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;   // [15:0] item_value, [23:16] priority_req
    logic [0:0]  i_s_tuser  = '0;   // [0] mode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // [15:0] out_value, [23:16] out_priority,
                                    // [28:24] fill_count, [31:29] zero
    logic [1:0]  o_m_tuser;         // [1:0] status

    queue_scoreboard board = new;
    bit              idle_enable = 1'b0;
    int              stall_left  = 0;
    int              cycle_count = 0;

    sorted_priority_queue #(.DEPTH(DEPTH)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Output side: check each transfer, then stall in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(o_m_tdata, o_m_tuser);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Offer one item and hold it until the transfer.
    task automatic push_item(logic mode, logic [VAL_W-1:0] val, logic [PRI_W-1:0] pri);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pri, val};
        i_s_tuser  <= mode;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        board.note_item(mode, val, pri);
    endtask

    task automatic run_directed();
        logic [PRI_W-1:0] tie_pri [4];
        tie_pri = '{8'd0, 8'd128, 8'd255, 8'd128};
        push_item(MODE_REMOVE, 16'hFFFF, 8'hFF);
        push_item(MODE_INSERT, 16'h0000, 8'd255);
        push_item(MODE_INSERT, 16'hFFFF, 8'd0);
        push_item(MODE_INSERT, 16'h1234, 8'd128);
        push_item(MODE_INSERT, 16'h5678, 8'd128);
        push_item(MODE_INSERT, 16'h9ABC, 8'd128);
        // fill to the brim, mixing ties at both ends of the priority range
        for (int n = 0; n < 11; n++)
            push_item(MODE_INSERT, 16'(16'hA000 + n), tie_pri[n % 4]);
        push_item(MODE_INSERT, 16'hFFFF, 8'd0);
        repeat (4) push_item(MODE_REMOVE, 16'h0000, 8'h00);
    endtask

    task automatic run_random();
        int               sent;
        int               burst;
        int               insert_pct;
        int               pri_kind;
        logic             mode;
        logic [PRI_W-1:0] pri;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst      = $urandom_range(10, 40);
            insert_pct = ($urandom_range(0, 2) == 0) ? 15 :
                         ($urandom_range(0, 1) == 0) ? 50 : 85;
            pri_kind   = $urandom_range(0, 2);
            idle_enable = (RANDOM_ITEMS - sent > CALM_TAIL) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < burst && sent < RANDOM_ITEMS; n++) begin
                if (RANDOM_ITEMS - sent <= CALM_TAIL)
                    idle_enable = 1'b0;
                mode = ($urandom_range(1, 100) <= insert_pct) ? MODE_INSERT : MODE_REMOVE;
                // narrow priority ranges force ties and ordering by arrival
                case (pri_kind)
                    0: pri = 8'($urandom_range(0, 3));
                    1: pri = 8'($urandom_range(250, 255));
                    default: pri = 8'($urandom);
                endcase
                push_item(mode, 16'($urandom), pri);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_enable = 1'b1;
        run_directed();
        run_random();
        i_s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        $display("covered: %0d inserts, %0d removes, %0d removes on empty, %0d drops on full",
                 board.n_inserted, board.n_removed, board.n_empty, board.n_full);
        $display("peak fill %0d of %0d, %0d cycles", board.peak_fill, DEPTH, cycle_count);
        if (board.fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
